@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the decoder top level.
// No dependencies; included by bmp24_to_rgb565_decoder, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Signal condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/b2r_pkg.sv @@
// Shared types and constants for the BMP 24-bit to RGB565 decoder.
// No dependencies; imported by b2r_hdr_chk, bmp24_to_rgb565_decoder and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package b2r_pkg;

    // Input request: one byte of the file
    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
    } t_in_item;

    // Result request: a pixel or an error report
    typedef struct packed {
        logic        result_kind;
        logic [15:0] color;
        logic [11:0] screen_x;
        logic [11:0] screen_y;
        logic        shown;
        logic        image_end;
        logic [2:0]  error_code;
    } t_out_item;

    // Display configuration registers
    typedef struct packed {
        logic [12:0] disp_w;
        logic [12:0] disp_h;
        logic [7:0]  origin_x;
        logic [7:0]  origin_y;
    } t_cfg;

    // Header field check status
    typedef struct packed {
        logic        err;
        logic [2:0]  code;
        logic        hgt_neg;
        logic [31:0] hgt_mag;
    } t_hdr_chk;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Error codes
    localparam logic [2:0] ERR_SIGNATURE   = 3'd0;
    localparam logic [2:0] ERR_PLANES      = 3'd1;
    localparam logic [2:0] ERR_FORMAT      = 3'd2;
    localparam logic [2:0] ERR_ORIGIN      = 3'd3;
    localparam logic [2:0] ERR_OFFSET_SIZE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_DISP_W   = 2'd0;
    localparam logic [1:0] CFG_DISP_H   = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_X = 2'd2;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd3;

    // Parse phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // Header byte positions where a field completes
    localparam logic [5:0] POS_ORIGIN      = 6'd0;
    localparam logic [5:0] POS_SIGNATURE   = 6'd1;
    localparam logic [5:0] POS_OFFSET      = 6'd13;
    localparam logic [5:0] POS_WIDTH       = 6'd21;
    localparam logic [5:0] POS_HEIGHT      = 6'd25;
    localparam logic [5:0] POS_PLANES      = 6'd27;
    localparam logic [5:0] POS_DEPTH       = 6'd29;
    localparam logic [5:0] POS_COMPRESSION = 6'd33;

    // Header field values
    localparam logic [15:0] BMP_SIGNATURE    = 16'h4D42;
    localparam logic [15:0] BMP_PLANES       = 16'd1;
    localparam logic [15:0] BMP_DEPTH        = 16'd24;
    localparam logic [31:0] MIN_PIXEL_OFFSET = 32'd34;

endpackage

`default_nettype wire

@@ hw/rtl/b2r_hdr_chk.sv @@
// Header field checker: flags a bad field on the byte that completes it.
// Depends on b2r_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b2r_hdr_chk #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic [5:0]        i_pos,
    input  wire logic [31:0]       i_hdr,
    input  wire b2r_pkg::t_cfg     i_cfg,
    output b2r_pkg::t_hdr_chk      o_chk
);
    import b2r_pkg::*;

    logic [31:0] w_mag;

    // Height magnitude from the signed field
    assign w_mag = i_hdr[31] ? (32'd0 - i_hdr) : i_hdr;

    always_comb begin
        o_chk         = '0;
        o_chk.code    = ERR_SIGNATURE;
        o_chk.hgt_neg = i_hdr[31];
        o_chk.hgt_mag = w_mag;
        unique case (i_pos)
            POS_ORIGIN: begin
                if ({5'd0, i_cfg.origin_x} >= i_cfg.disp_w
                    || {5'd0, i_cfg.origin_y} >= i_cfg.disp_h) begin
                    o_chk.err  = 1'b1;
                    o_chk.code = ERR_ORIGIN;
                end
            end
            POS_SIGNATURE: begin
                if (i_hdr[31:16] != BMP_SIGNATURE) begin
                    o_chk.err  = 1'b1;
                    o_chk.code = ERR_SIGNATURE;
                end
            end
            POS_OFFSET: begin
                if (i_hdr < MIN_PIXEL_OFFSET) begin
                    o_chk.err  = 1'b1;
                    o_chk.code = ERR_OFFSET_SIZE;
                end
            end
            POS_WIDTH: begin
                // negative widths read as huge and fail the bound
                if (i_hdr == 32'd0 || i_hdr > 32'(MAX_DIMENSION)) begin
                    o_chk.err  = 1'b1;
                    o_chk.code = ERR_OFFSET_SIZE;
                end
            end
            POS_HEIGHT: begin
                if (w_mag == 32'd0 || w_mag > 32'(MAX_DIMENSION)) begin
                    o_chk.err  = 1'b1;
                    o_chk.code = ERR_OFFSET_SIZE;
                end
            end
            POS_PLANES: begin
                if (i_hdr[31:16] != BMP_PLANES) begin
                    o_chk.err  = 1'b1;
                    o_chk.code = ERR_PLANES;
                end
            end
            POS_DEPTH: begin
                if (i_hdr[31:16] != BMP_DEPTH) begin
                    o_chk.err  = 1'b1;
                    o_chk.code = ERR_FORMAT;
                end
            end
            POS_COMPRESSION: begin
                if (i_hdr != 32'd0) begin
                    o_chk.err  = 1'b1;
                    o_chk.code = ERR_FORMAT;
                end
            end
            default: begin
                o_chk.err = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/bmp24_to_rgb565_decoder.sv @@
// BMP 24-bit to RGB565 stream decoder, top level.
// Depends on b2r_pkg, b2r_hdr_chk and assert_macros.svh.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_data) takes the file one
//    byte per request, in file order; first_byte restarts the parse.
//  - Output channel (o_out_valid / i_out_ready / o_out_data) gives at most
//    one request per byte: an RGB565 pixel tagged with display coordinates,
//    or an error report after which bytes are dropped until the next file.
//  - Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//    writes display size and image origin; it is always ready. Write it
//    only while no byte is in flight.
//  - A byte is held in the input register, its result in the result register.
//  - Throughput: one byte per cycle. All per-byte work is one pass of
//    counter updates and compares between the input register and the
//    result register; the skip compare is a single 32-bit equality.
//  - Stall: the input register holds one byte while the result register
//    waits on i_out_ready, so one more byte is taken before o_in_ready drops.
//  - Reset (synchronous, active low): parser to header phase, display
//    128x160, origin 0,0, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bmp24_to_rgb565_decoder #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte input
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire b2r_pkg::t_in_item  i_in_data,
    // result output
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output b2r_pkg::t_out_item      o_out_data,
    // configuration writes
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [12:0]        i_cfg_data
);
    import b2r_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int ROW_W = DIM_W + 2;
    localparam int CRD_W = (DIM_W + 1 > 13) ? DIM_W + 1 : 13;

    // Configuration
    t_cfg              r_cfg;

    // Pipeline registers
    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    t_out_item         r_out;

    // Parser state
    logic [1:0]        r_phase,      n_phase;
    logic [31:0]       r_pos,        n_pos;
    logic [31:0]       r_hdr,        n_hdr;
    logic [31:0]       r_pix_off,    n_pix_off;
    logic [DIM_W-1:0]  r_w_last,     n_w_last;
    logic [DIM_W-1:0]  r_h_last,     n_h_last;
    logic              r_bottom_up,  n_bottom_up;
    logic [ROW_W-1:0]  r_data_bytes, n_data_bytes;
    logic [ROW_W-1:0]  r_row_last,   n_row_last;
    logic [DIM_W-1:0]  r_row,        n_row;
    logic [ROW_W-1:0]  r_bir,        n_bir;
    logic [1:0]        r_tri,        n_tri;
    logic [DIM_W-1:0]  r_col,        n_col;
    logic [15:0]       r_bg,         n_bg;

    // Per-byte combinational signals
    logic              w_proc;
    logic [1:0]        w_phase;
    logic [31:0]       w_pos;
    logic [31:0]       w_hs;
    t_hdr_chk          w_chk;
    logic              w_pix_step;
    logic              w_in_data;
    logic              w_finished;
    logic              w_emit;
    logic              w_err;
    t_out_item         w_res;
    logic [DIM_W-1:0]  w_width;
    logic [ROW_W-1:0]  w_w3;
    logic [ROW_W-1:0]  w_row_bytes;
    logic [DIM_W-1:0]  w_img_row;
    logic [CRD_W-1:0]  w_sx;
    logic [CRD_W-1:0]  w_sy;

    // Handshakes
    assign w_proc      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_proc;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Restart view of the state for a first byte
    assign w_phase = r_in.first_byte ? PH_HEADER : r_phase;
    assign w_pos   = r_in.first_byte ? 32'd0 : r_pos;
    assign w_hs    = {r_in.file_byte, (r_in.first_byte ? 24'd0 : r_hdr[31:8])};

    b2r_hdr_chk #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_hdr_chk (
        .i_pos (w_pos[5:0]),
        .i_hdr (w_hs),
        .i_cfg (r_cfg),
        .o_chk (w_chk)
    );

    // Row geometry from the width field
    assign w_width     = w_hs[DIM_W-1:0];
    assign w_w3        = ({2'b00, w_width} << 1) + {2'b00, w_width};
    assign w_row_bytes = (w_w3 + ROW_W'(3)) & ~ROW_W'(3);

    // Pixel coordinates
    assign w_in_data  = r_bir < r_data_bytes;
    assign w_img_row  = r_bottom_up ? (r_h_last - r_row) : r_row;
    assign w_sx       = CRD_W'(r_cfg.origin_x) + CRD_W'(r_col);
    assign w_sy       = CRD_W'(r_cfg.origin_y) + CRD_W'(w_img_row);
    assign w_pix_step = (w_phase == PH_PIXELS)
                        || (w_phase == PH_SKIP && w_pos == r_pix_off);
    assign w_finished = w_pix_step && w_in_data && r_tri == 2'd2
                        && r_col == r_w_last && r_row == r_h_last;

    // Next state and result for one byte
    always_comb begin
        n_phase      = w_phase;
        n_pos        = w_pos + 32'd1;
        n_hdr        = r_hdr;
        n_pix_off    = r_pix_off;
        n_w_last     = r_w_last;
        n_h_last     = r_h_last;
        n_bottom_up  = r_bottom_up;
        n_data_bytes = r_data_bytes;
        n_row_last   = r_row_last;
        n_row        = r_row;
        n_bir        = r_bir;
        n_tri        = r_tri;
        n_col        = r_col;
        n_bg         = r_bg;
        w_emit       = 1'b0;
        w_err        = 1'b0;
        w_res        = '0;

        if (w_phase == PH_HEADER) begin
            n_hdr = w_hs;
            if (w_chk.err) begin
                w_emit            = 1'b1;
                w_err             = 1'b1;
                w_res.result_kind = KIND_ERROR;
                w_res.error_code  = w_chk.code;
                n_phase           = PH_DONE;
            end else begin
                unique case (w_pos[5:0])
                    POS_OFFSET: begin
                        n_pix_off = w_hs;
                    end
                    POS_WIDTH: begin
                        n_w_last     = w_width - DIM_W'(1);
                        n_data_bytes = w_w3;
                        n_row_last   = w_row_bytes - ROW_W'(1);
                    end
                    POS_HEIGHT: begin
                        n_h_last    = w_chk.hgt_mag[DIM_W-1:0] - DIM_W'(1);
                        n_bottom_up = !w_chk.hgt_neg;
                    end
                    POS_COMPRESSION: begin
                        n_row   = '0;
                        n_bir   = '0;
                        n_tri   = 2'd0;
                        n_col   = '0;
                        n_bg    = '0;
                        n_phase = PH_SKIP;
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end else if (w_pix_step) begin
            n_phase = PH_PIXELS;
            // gather blue and green, emit on red
            if (w_in_data) begin
                unique case (r_tri)
                    2'd0: n_bg[7:0]  = r_in.file_byte;
                    2'd1: n_bg[15:8] = r_in.file_byte;
                    2'd2: begin
                        w_emit            = 1'b1;
                        w_res.result_kind = KIND_PIXEL;
                        w_res.color       = {r_in.file_byte[7:3], r_bg[15:10], r_bg[7:3]};
                        w_res.screen_x    = w_sx[11:0];
                        w_res.screen_y    = w_sy[11:0];
                        w_res.shown       = (w_sx < CRD_W'(r_cfg.disp_w))
                                            && (w_sy < CRD_W'(r_cfg.disp_h));
                        w_res.image_end   = w_finished;
                    end
                    default: n_bg = r_bg;
                endcase
            end
            // advance through the row, padding included
            if (w_finished) begin
                n_phase = PH_DONE;
            end else if (r_bir == r_row_last) begin
                n_bir = '0;
                n_row = r_row + DIM_W'(1);
                n_tri = 2'd0;
                n_col = '0;
            end else begin
                n_bir = r_bir + ROW_W'(1);
                if (w_in_data) begin
                    n_tri = (r_tri == 2'd2) ? 2'd0 : r_tri + 2'd1;
                    n_col = (r_tri == 2'd2) ? r_col + DIM_W'(1) : r_col;
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.disp_w   <= 13'd128;
            r_cfg.disp_h   <= 13'd160;
            r_cfg.origin_x <= 8'd0;
            r_cfg.origin_y <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DISP_W:   r_cfg.disp_w   <= i_cfg_data;
                CFG_DISP_H:   r_cfg.disp_h   <= i_cfg_data;
                CFG_ORIGIN_X: r_cfg.origin_x <= i_cfg_data[7:0];
                CFG_ORIGIN_Y: r_cfg.origin_y <= i_cfg_data[7:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_emit) begin
            r_out <= w_res;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_pos        <= '0;
            r_hdr        <= '0;
            r_pix_off    <= '0;
            r_w_last     <= '0;
            r_h_last     <= '0;
            r_bottom_up  <= 1'b1;
            r_data_bytes <= '0;
            r_row_last   <= '0;
            r_row        <= '0;
            r_bir        <= '0;
            r_tri        <= 2'd0;
            r_col        <= '0;
            r_bg         <= '0;
        end else if (w_proc) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_hdr        <= n_hdr;
            r_pix_off    <= n_pix_off;
            r_w_last     <= n_w_last;
            r_h_last     <= n_h_last;
            r_bottom_up  <= n_bottom_up;
            r_data_bytes <= n_data_bytes;
            r_row_last   <= n_row_last;
            r_row        <= n_row;
            r_bir        <= n_bir;
            r_tri        <= n_tri;
            r_col        <= n_col;
            r_bg         <= n_bg;
        end
    end

    // Checks
    `ASSERT_CLK(a_err_to_done, i_clk, i_rst_n, (w_proc && w_err) |=> (r_phase == PH_DONE), "error report did not end the parse")
    `ASSERT_CLK(a_end_to_done, i_clk, i_rst_n, (w_proc && w_finished) |=> (r_phase == PH_DONE), "last pixel did not end the parse")
    `ASSERT_CLK(a_err_code, i_clk, i_rst_n, (r_out_valid && r_out.result_kind == KIND_ERROR) |-> (r_out.error_code <= ERR_OFFSET_SIZE), "error code out of range")
    `ASSERT_NEVER(a_tri_range, i_clk, i_rst_n, r_tri == 2'd3, "byte-in-pixel counter out of range")
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, (r_in_valid && !w_proc) |=> (r_in_valid && $stable(r_in)), "held input byte lost")

endmodule

`default_nettype wire

@@ dv/bmp24_to_rgb565_decoder_tb.sv @@
// Self-checking testbench for bmp24_to_rgb565_decoder: streams BMP files byte by byte,
// predicts every pixel and error report in a local decoder and checks each result request.
// Depends on b2r_pkg and the decoder RTL.
`timescale 1ns / 1ps

module bmp24_to_rgb565_decoder_tb;
    import b2r_pkg::*;

    localparam logic [31:0] MAX_DIM = 32'd4096;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_DISP_W;
    logic [12:0] i_cfg_data = '0;

    bmp24_to_rgb565_decoder DUT (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_ready, .i_in_data,
        .o_out_valid, .i_out_ready, .o_out_data,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    // Byte requests waiting to be sent, and decoded results waiting to arrive
    t_in_item  file_bytes[$];
    t_out_item decoded_queue[$];
    int        queued_bytes = 0;
    int        mismatches = 0;
    int        in_gap = 0, in_calm = 0, out_stall = 0, out_calm = 0;

    // Local copy of the display setup
    logic [12:0] disp_w, disp_h;
    logic [7:0]  org_x, org_y;

    // Local copy of the parser state
    logic [31:0] byte_pos, hdr_shift, pix_offset;
    logic [12:0] img_w, img_h, file_row;
    logic        rows_up;
    logic [14:0] row_byte;
    logic [15:0] bg_hold;
    logic [1:0]  parse_phase;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void restart_decode();
        byte_pos = '0; hdr_shift = '0; pix_offset = '0;
        img_w = '0; img_h = '0; rows_up = 1'b1;
        file_row = '0; row_byte = '0; bg_hold = '0;
        parse_phase = PH_HEADER;
    endfunction

    function automatic bit flag_error(output t_out_item res, input logic [2:0] code);
        res = '0;
        res.result_kind = KIND_ERROR;
        res.error_code = code;
        parse_phase = PH_DONE;
        return 1'b1;
    endfunction

    // Decode one file byte; returns 1 when it yields a result
    function automatic bit decode_byte(input t_in_item it, output t_out_item res);
        logic [31:0] pos, hs, mag, data_bytes, row_bytes, col, img_row, sx, sy;
        logic [7:0]  b;
        bit          done_img, emitted;
        res = '0;
        emitted = 1'b0;
        b = it.file_byte;
        if (it.first_byte)
            restart_decode();
        pos = byte_pos;
        byte_pos = pos + 32'd1;

        // header fields are checked on their last byte
        if (parse_phase == PH_HEADER) begin
            hs = {b, hdr_shift[31:8]};
            hdr_shift = hs;
            case (pos)
                POS_ORIGIN: begin
                    if (org_x >= disp_w || org_y >= disp_h)
                        return flag_error(res, ERR_ORIGIN);
                end
                POS_SIGNATURE: begin
                    if (hs[31:16] != BMP_SIGNATURE)
                        return flag_error(res, ERR_SIGNATURE);
                end
                POS_OFFSET: begin
                    pix_offset = hs;
                    if (hs < MIN_PIXEL_OFFSET)
                        return flag_error(res, ERR_OFFSET_SIZE);
                end
                POS_WIDTH: begin
                    if (hs == 32'd0 || hs > MAX_DIM)
                        return flag_error(res, ERR_OFFSET_SIZE);
                    img_w = hs[12:0];
                end
                POS_HEIGHT: begin
                    mag = hs[31] ? (32'd0 - hs) : hs;
                    if (mag == 32'd0 || mag > MAX_DIM)
                        return flag_error(res, ERR_OFFSET_SIZE);
                    img_h = mag[12:0];
                    rows_up = ~hs[31];
                end
                POS_PLANES: begin
                    if (hs[31:16] != BMP_PLANES)
                        return flag_error(res, ERR_PLANES);
                end
                POS_DEPTH: begin
                    if (hs[31:16] != BMP_DEPTH)
                        return flag_error(res, ERR_FORMAT);
                end
                POS_COMPRESSION: begin
                    if (hs != 32'd0)
                        return flag_error(res, ERR_FORMAT);
                    file_row = '0; row_byte = '0; bg_hold = '0;
                    parse_phase = PH_SKIP;
                end
                default: ;
            endcase
            return 1'b0;
        end

        if (parse_phase == PH_SKIP) begin
            if (pos != pix_offset)
                return 1'b0;
            parse_phase = PH_PIXELS;
        end
        if (parse_phase != PH_PIXELS)
            return 1'b0;

        // pixel bytes: blue, green, red; row padding makes no result
        data_bytes = 32'd3 * img_w;
        row_bytes = (data_bytes + 32'd3) & ~32'd3;
        done_img = 1'b0;
        if (row_byte < data_bytes) begin
            case (row_byte % 3)
                0: bg_hold = {8'h00, b};
                1: bg_hold[15:8] = b;
                default: begin
                    col = row_byte / 3;
                    img_row = rows_up ? (img_h - 32'd1 - file_row) : {19'd0, file_row};
                    sx = org_x + col;
                    sy = org_y + img_row;
                    done_img = (col + 32'd1 == img_w) && (file_row + 32'd1 == img_h);
                    res.result_kind = KIND_PIXEL;
                    res.color = {b[7:3], bg_hold[15:10], bg_hold[7:3]};
                    res.screen_x = sx[11:0];
                    res.screen_y = sy[11:0];
                    res.shown = (sx < disp_w) && (sy < disp_h);
                    res.image_end = done_img;
                    emitted = 1'b1;
                end
            endcase
        end
        if (done_img) begin
            parse_phase = PH_DONE;
        end else if (row_byte + 32'd1 >= row_bytes) begin
            row_byte = '0;
            file_row = file_row + 13'd1;
        end else begin
            row_byte = row_byte + 15'd1;
        end
        return emitted;
    endfunction

    // Idle lengths: mostly none or short, a few long, with calm stretches
    function automatic int pick_gap(ref int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 199) == 0)
            calm = $urandom_range(40, 200);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic string show_result(input t_out_item r);
        return $sformatf("kind %0d color %h x %0d y %0d shown %0d end %0d code %0d",
                         r.result_kind, r.color, r.screen_x, r.screen_y, r.shown,
                         r.image_end, r.error_code);
    endfunction

    // Byte driver: predicts each accepted request, then offers the next one
    always @(posedge i_clk) begin : drive_bytes
        t_out_item res;
        logic      nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                if (decode_byte(i_in_data, res))
                    decoded_queue.push_back(res);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (file_bytes.size() > 0) begin
                    i_in_data <= file_bytes.pop_front();
                    nxt_valid = 1'b1;
                    in_gap = pick_gap(in_calm);
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // Result monitor: compares each result request with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (decoded_queue.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result: %s", $realtime,
                                 show_result(o_out_data));
                    mismatches++;
                end else begin
                    want = decoded_queue.pop_front();
                    if (o_out_data.result_kind !== want.result_kind ||
                        o_out_data.color !== want.color ||
                        o_out_data.screen_x !== want.screen_x ||
                        o_out_data.screen_y !== want.screen_y ||
                        o_out_data.shown !== want.shown ||
                        o_out_data.image_end !== want.image_end ||
                        o_out_data.error_code !== want.error_code) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch, expected %s", $realtime, show_result(want));
                            $display("%0t:           actual   %s", $realtime,
                                     show_result(o_out_data));
                        end
                        mismatches++;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                out_stall = pick_gap(out_calm);
            end
        end
    end

    // Little-endian field, first byte optionally flagged as file start
    task automatic push_word(input logic [31:0] v, input int n, input bit first);
        t_in_item it;
        for (int i = 0; i < n; i++) begin
            it.file_byte = v[8*i +: 8];
            it.first_byte = first && (i == 0);
            file_bytes.push_back(it);
            queued_bytes++;
        end
    endtask

    // One file: 34-byte header, filler up to the offset, rows with padding.
    // cut >= 0 stops the body early; bad headers get a few ignored bytes.
    task automatic queue_bmp(input logic [15:0] sig, input logic [31:0] offv,
                             input logic [31:0] wid, input logic [31:0] hgt,
                             input logic [15:0] planes, input logic [15:0] depth,
                             input logic [31:0] comp, input int cut);
        int mag, row_len, body;
        bit good;
        push_word({16'd0, sig}, 2, 1'b1);
        push_word($urandom, 4, 1'b0);
        push_word($urandom, 4, 1'b0);
        push_word(offv, 4, 1'b0);
        push_word(32'd40, 4, 1'b0);
        push_word(wid, 4, 1'b0);
        push_word(hgt, 4, 1'b0);
        push_word({16'd0, planes}, 2, 1'b0);
        push_word({16'd0, depth}, 2, 1'b0);
        push_word(comp, 4, 1'b0);
        mag = hgt[31] ? int'(32'd0 - hgt) : int'(hgt);
        good = sig == BMP_SIGNATURE && offv >= MIN_PIXEL_OFFSET && offv < 32'd1000 &&
               wid != 0 && wid <= MAX_DIM && mag >= 1 && mag <= int'(MAX_DIM) &&
               planes == BMP_PLANES && depth == BMP_DEPTH && comp == 32'd0;
        if (good) begin
            row_len = (3 * int'(wid) + 3) & ~3;
            body = int'(offv) - 34 + row_len * mag + $urandom_range(0, 3);
            if (cut >= 0 && cut < body)
                body = cut;
        end else begin
            body = (cut >= 0) ? cut : $urandom_range(0, 4);
        end
        for (int i = 0; i < body; i++)
            push_word($urandom_range(0, 255), 1, 1'b0);
    endtask

    task automatic queue_good(input int w, input int h, input int offs, input int cut);
        queue_bmp(BMP_SIGNATURE, 32'(offs), 32'(w), 32'(h), BMP_PLANES, BMP_DEPTH,
                  32'd0, cut);
    endtask

    // Small random file, a quarter of them with one broken header field
    task automatic queue_random_file();
        int          w, h, cut;
        logic [15:0] sig, planes, depth;
        logic [31:0] offv, wid, hgt, comp;
        w = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        h = $urandom_range(1, 5);
        if ($urandom_range(0, 1))
            h = -h;
        offv = ($urandom_range(0, 3) == 0) ? $urandom_range(35, 60) : 32'd34;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : -1;
        sig = BMP_SIGNATURE; wid = 32'(w); hgt = 32'(h);
        planes = BMP_PLANES; depth = BMP_DEPTH; comp = '0;
        case ($urandom_range(0, 27))
            0: sig = sig ^ (16'd1 << $urandom_range(0, 15));
            1: offv = $urandom_range(0, 33);
            2: begin
                case ($urandom_range(0, 2))
                    0: wid = '0;
                    1: wid = $urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF);
                    default: wid = 32'h8000_0000 | $urandom;
                endcase
            end
            3: begin
                case ($urandom_range(0, 2))
                    0: hgt = '0;
                    1: hgt = MAX_DIM + 32'd1 + $urandom_range(0, 5000);
                    default: hgt = 32'd0 - (MAX_DIM + 32'd1 + $urandom_range(0, 5000));
                endcase
            end
            4: planes = planes ^ (16'd1 << $urandom_range(0, 15));
            5: depth = depth ^ (16'd1 << $urandom_range(0, 15));
            6: comp = 32'd1 << $urandom_range(0, 31);
            default: ;
        endcase
        queue_bmp(sig, offv, wid, hgt, planes, depth, comp, cut);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [12:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DISP_W:   disp_w = val;
            CFG_DISP_H:   disp_h = val;
            CFG_ORIGIN_X: org_x = val[7:0];
            CFG_ORIGIN_Y: org_y = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_display(input int w, input int h, input int ox, input int oy);
        cfg_write(CFG_DISP_W, 13'(w));
        cfg_write(CFG_DISP_H, 13'(h));
        cfg_write(CFG_ORIGIN_X, 13'(ox));
        cfg_write(CFG_ORIGIN_Y, 13'(oy));
        i_cfg_valid <= 1'b0;
    endtask

    // All bytes sent, all results in, then let any padding byte drain
    task automatic wait_idle();
        while (file_bytes.size() != 0 || i_in_valid || decoded_queue.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 5))
            0: return 1;
            1: return int'(MAX_DIM);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    initial begin
        int dw, dh, ox, oy, start;
        restart_decode();
        disp_w = 13'd128; disp_h = 13'd160; org_x = '0; org_y = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset display: good files, padding, restart mid-file, each header error
        queue_good(1, 1, 34, -1);
        queue_good(2, -2, 54, -1);
        queue_good(3, 2, 34, -1);
        queue_good(4, 3, 40, 10);
        queue_bmp(16'h424D, 32'd34, 32'd1, 32'd1, BMP_PLANES, BMP_DEPTH, 32'd0, -1);
        queue_bmp(BMP_SIGNATURE, 32'd33, 32'd1, 32'd1, BMP_PLANES, BMP_DEPTH, 32'd0, -1);
        queue_bmp(BMP_SIGNATURE, 32'd34, 32'd0, 32'd1, BMP_PLANES, BMP_DEPTH, 32'd0, -1);
        queue_bmp(BMP_SIGNATURE, 32'd34, 32'd4097, 32'd1, BMP_PLANES, BMP_DEPTH, 32'd0, -1);
        queue_bmp(BMP_SIGNATURE, 32'd34, 32'hFFFF_FFFF, 32'd1, BMP_PLANES, BMP_DEPTH,
                  32'd0, -1);
        queue_bmp(BMP_SIGNATURE, 32'd34, 32'd1, 32'd0, BMP_PLANES, BMP_DEPTH, 32'd0, -1);
        queue_bmp(BMP_SIGNATURE, 32'd34, 32'd1, 32'd4097, BMP_PLANES, BMP_DEPTH, 32'd0, -1);
        queue_bmp(BMP_SIGNATURE, 32'd34, 32'd1, -32'sd4097, BMP_PLANES, BMP_DEPTH, 32'd0, -1);
        queue_bmp(BMP_SIGNATURE, 32'd34, 32'd1, 32'd1, 16'd2, BMP_DEPTH, 32'd0, -1);
        queue_bmp(BMP_SIGNATURE, 32'd34, 32'd1, 32'd1, BMP_PLANES, 16'd32, 32'd0, -1);
        queue_bmp(BMP_SIGNATURE, 32'd34, 32'd1, 32'd1, BMP_PLANES, BMP_DEPTH, 32'd1, -1);
        queue_good(2, 1, 34, -1);
        wait_idle();

        // largest image sizes, cut short; bottom rows land past 12 bits
        set_display(4096, 4096, 255, 255);
        queue_good(4096, -1, 34, 10);
        queue_good(1, 4096, 34, 40);
        wait_idle();

        // one-pixel display, then origin on and just past the display edge
        set_display(1, 1, 0, 0);
        queue_good(2, 2, 34, -1);
        wait_idle();
        set_display(8, 6, 8, 0);
        queue_good(2, 2, 34, -1);
        wait_idle();
        set_display(8, 6, 7, 6);
        queue_good(2, 2, 34, -1);
        wait_idle();
        set_display(8, 6, 7, 5);
        queue_good(2, -2, 34, -1);
        wait_idle();

        // random displays and files, with stray bytes between files
        for (int ph = 0; ph < 3; ph++) begin
            dw = pick_dim();
            dh = pick_dim();
            if ($urandom_range(0, 9) == 0) begin
                ox = $urandom_range(0, 255);
                oy = $urandom_range(0, 255);
            end else begin
                ox = $urandom_range(0, (dw > 256) ? 255 : dw - 1);
                oy = $urandom_range(0, (dh > 256) ? 255 : dh - 1);
            end
            set_display(dw, dh, ox, oy);
            start = queued_bytes;
            while (queued_bytes - start < 40) begin
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 6))
                        push_word($urandom_range(0, 255), 1, $urandom_range(0, 3) == 0);
                end
                queue_random_file();
            end
            wait_idle();
        end

        if (mismatches == 0 && decoded_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/b2r_pkg.sv
hw/rtl/b2r_hdr_chk.sv
hw/rtl/bmp24_to_rgb565_decoder.sv
dv/bmp24_to_rgb565_decoder_tb.sv
